[sv/cle_pkg.sv]
package cle_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       read_started;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] erase_count;
        logic       end_of_line;
        logic       end_of_file;
        logic       line_ready;
        logic       last;
    } t_out;

    localparam logic [2:0] KIND_ECHO  = 3'd0;
    localparam logic [2:0] KIND_ERASE = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_PLIST = 3'd4;

    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_COMMIT  = 8'h01;
    localparam logic [7:0] CHR_CTRL_D  = 8'h04;
    localparam logic [7:0] CHR_CTRL_H  = 8'h08;
    localparam logic [7:0] CHR_NL      = 8'h0a;
    localparam logic [7:0] CHR_CR      = 8'h0d;
    localparam logic [7:0] CHR_CTRL_P  = 8'h10;
    localparam logic [7:0] CHR_CTRL_U  = 8'h15;
    localparam logic [7:0] CHR_ESC     = 8'h1b;
    localparam logic [7:0] CHR_BRACKET = 8'h5b;
    localparam logic [7:0] CHR_DEL     = 8'h7f;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_DROP1 = 3'b010,
        ESC_DROP2 = 3'b100
    } t_esc;

endpackage

[sv/cle_res_queue.sv]
module cle_res_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  cle_pkg::t_out              i_push_a,
    input  cle_pkg::t_out              i_push_b,
    input  logic                       i_pop,
    output logic [cle_pkg::Q_CW-1:0]   o_count,
    output cle_pkg::t_out              o_head
);
    import cle_pkg::*;

    t_out            r_slot [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_PW-1:0] n_wr_ptr;
    logic [Q_PW-1:0] n_rd_ptr;
    logic [Q_CW-1:0] n_count;
    logic [Q_PW-1:0] w_wr_next;

    assign w_wr_next = Q_PW'(r_wr_ptr + 1'b1);

    always_comb begin
        n_wr_ptr = Q_PW'(r_wr_ptr + Q_PW'(i_push_cnt));
        n_rd_ptr = i_pop ? Q_PW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = Q_CW'(r_count + Q_CW'(i_push_cnt) - Q_CW'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_slot[r_wr_ptr] <= i_push_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_slot[w_wr_next] <= i_push_b;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_slot[r_rd_ptr];

endmodule

[sv/console_line_editor.sv]
// Line-editing console input ring. Each request is either a received byte or a
// read request from the consumer, and one request is taken every clock cycle
// while the result queue has room for two more results. The results of a
// request pass the stage-1 registers and the result queue before they leave;
// a request causes zero, one or two results, and the last one carries last.
// The line buffer is one single-port memory of BUF_DEPTH bytes with registered
// read data, so a request uses the port at most once; a read that meets Ctrl-D
// decides its pointer advance in the cycle after it is taken, and the next
// request sees the decision through forwarding. No clearing pass follows reset.
module console_line_editor #(
    parameter int BUF_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cle_pkg::t_out o_out_data
);
    import cle_pkg::*;

    localparam int PTR_MOD = 2 * BUF_DEPTH;
    localparam int PW      = $clog2(PTR_MOD);
    localparam int AW      = $clog2(BUF_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);
    localparam logic [PW-1:0] MOD_P   = PW'(PTR_MOD);
    localparam logic [PW-1:0] LAST_P  = PW'(PTR_MOD - 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST_P) ? '0 : PW'(p + 1'b1);
    endfunction

    function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
        return (p == '0) ? LAST_P : PW'(p - 1'b1);
    endfunction

    function automatic logic [PW-1:0] ring_diff(input logic [PW-1:0] a,
                                                input logic [PW-1:0] b);
        return (a >= b) ? PW'(a - b) : PW'(a - b + MOD_P);
    endfunction

    function automatic logic [AW-1:0] ring_idx(input logic [PW-1:0] p);
        return (p >= DEPTH_P) ? AW'(p - DEPTH_P) : AW'(p);
    endfunction

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rdata;
    logic [PW-1:0] r_read_pos, n_read_pos;
    logic [PW-1:0] r_commit_pos, n_commit_pos;
    logic [PW-1:0] r_edit_pos, n_edit_pos;
    t_esc          r_esc, n_esc;
    logic [1:0]    r_s1_nres, n_s1_nres;
    logic          r_s1_rd, n_s1_rd;
    logic          r_s1_started, n_s1_started;
    t_out          r_s1_res0, n_s1_res0;
    t_out          r_s1_res1, n_s1_res1;

    logic          w_accept;
    logic          w_s1_advance;
    logic [PW-1:0] w_rp_eff;
    logic [PW-1:0] w_ucount;
    logic [PW-1:0] w_fill;
    logic [7:0]    w_char;
    logic [7:0]    w_stored;
    logic          w_mem_we;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_addr;
    t_out          w_push_a;
    logic          w_pop;
    logic [Q_CW-1:0] w_q_count;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_char   = i_in_data.rx_byte;
    assign w_stored = (w_char == CHR_CR) ? CHR_NL : w_char;

    assign w_s1_advance = r_s1_rd && ((r_rdata != CHR_CTRL_D) || !r_s1_started);
    assign w_rp_eff     = w_s1_advance ? ring_next(r_read_pos) : r_read_pos;
    assign w_ucount     = ring_diff(r_edit_pos, r_commit_pos);
    assign w_fill       = ring_diff(r_edit_pos, w_rp_eff);

    always_comb begin
        w_push_a = r_s1_res0;
        if (r_s1_rd) begin
            w_push_a       = '0;
            w_push_a.kind  = KIND_READ;
            w_push_a.last  = 1'b1;
            if (r_rdata == CHR_CTRL_D) begin
                w_push_a.end_of_file = 1'b1;
            end else begin
                w_push_a.data        = r_rdata;
                w_push_a.end_of_line = (r_rdata == CHR_NL);
            end
        end
    end

    always_comb begin
        n_read_pos   = w_rp_eff;
        n_commit_pos = r_commit_pos;
        n_edit_pos   = r_edit_pos;
        n_esc        = r_esc;
        n_s1_nres    = 2'd0;
        n_s1_rd      = 1'b0;
        n_s1_started = i_in_data.read_started;
        n_s1_res0    = '0;
        n_s1_res1    = '0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_mem_addr   = ring_idx(w_rp_eff);
        if (w_accept) begin
            if (i_in_data.mode) begin
                n_s1_nres = 2'd1;
                if (w_rp_eff == r_commit_pos) begin
                    n_s1_res0.kind = KIND_EMPTY;
                    n_s1_res0.last = 1'b1;
                end else begin
                    n_s1_rd  = 1'b1;
                    w_mem_re = 1'b1;
                end
            end else begin
                case (r_esc)
                    ESC_DROP1: begin
                        n_esc = (w_char == CHR_BRACKET) ? ESC_DROP2 : ESC_NONE;
                    end
                    ESC_DROP2: begin
                        n_esc = ESC_NONE;
                    end
                    default: begin
                        n_esc = ESC_NONE;
                        case (w_char)
                            CHR_CTRL_P: begin
                                n_s1_nres      = 2'd1;
                                n_s1_res0.kind = KIND_PLIST;
                                n_s1_res0.last = 1'b1;
                            end
                            CHR_CTRL_U: begin
                                if (w_ucount != '0) begin
                                    n_edit_pos     = r_commit_pos;
                                    n_s1_nres      = 2'd1;
                                    n_s1_res0.kind = KIND_ERASE;
                                    n_s1_res0.erase_count =
                                        (32'(w_ucount) > 32'd255) ? 8'd255 : 8'(w_ucount);
                                    n_s1_res0.last = 1'b1;
                                end
                            end
                            CHR_CTRL_H, CHR_DEL: begin
                                if (r_edit_pos != r_commit_pos) begin
                                    n_edit_pos            = ring_prev(r_edit_pos);
                                    n_s1_nres             = 2'd1;
                                    n_s1_res0.kind        = KIND_ERASE;
                                    n_s1_res0.erase_count = 8'd1;
                                    n_s1_res0.last        = 1'b1;
                                end
                            end
                            CHR_ESC: begin
                                n_esc = ESC_DROP1;
                            end
                            default: begin
                                if ((w_char != CHR_NUL) && (w_fill < DEPTH_P)) begin
                                    w_mem_we       = 1'b1;
                                    w_mem_addr     = ring_idx(r_edit_pos);
                                    n_edit_pos     = ring_next(r_edit_pos);
                                    n_s1_res0.kind = KIND_ECHO;
                                    n_s1_res0.data = w_stored;
                                    if ((w_stored == CHR_NL) || (w_stored == CHR_CTRL_D) ||
                                        (w_fill == PW'(DEPTH_P - 1'b1))) begin
                                        n_commit_pos         = ring_next(r_edit_pos);
                                        n_s1_nres            = 2'd2;
                                        n_s1_res1.kind       = KIND_ECHO;
                                        n_s1_res1.data       = CHR_COMMIT;
                                        n_s1_res1.line_ready = 1'b1;
                                        n_s1_res1.last       = 1'b1;
                                    end else begin
                                        n_s1_nres      = 2'd1;
                                        n_s1_res0.last = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pos   <= '0;
            r_commit_pos <= '0;
            r_edit_pos   <= '0;
            r_esc        <= ESC_NONE;
            r_s1_nres    <= 2'd0;
            r_s1_rd      <= 1'b0;
        end else begin
            r_read_pos   <= n_read_pos;
            r_commit_pos <= n_commit_pos;
            r_edit_pos   <= n_edit_pos;
            r_esc        <= n_esc;
            r_s1_nres    <= n_s1_nres;
            r_s1_rd      <= n_s1_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_started <= n_s1_started;
        r_s1_res0    <= n_s1_res0;
        r_s1_res1    <= n_s1_res1;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_stored;
        end else if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_addr];
        end
    end

    assign w_pop       = (w_q_count != '0) && !i_out_stall;
    assign o_out_valid = (w_q_count != '0);
    assign o_in_stall  = (Q_CW'(w_q_count + Q_CW'(r_s1_nres)) > Q_CW'(Q_DEPTH - 2));

    cle_res_queue u_res_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (r_s1_nres),
        .i_push_a   (w_push_a),
        .i_push_b   (r_s1_res1),
        .i_pop      (w_pop),
        .o_count    (w_q_count),
        .o_head     (o_out_data)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= Q_CW'(Q_DEPTH))
        else $error("Result queue holds more entries than it has.");

    a_ring_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ring_diff(r_edit_pos, r_read_pos) <= DEPTH_P) &&
        (ring_diff(r_commit_pos, r_read_pos) <= ring_diff(r_edit_pos, r_read_pos)))
        else $error("Ring positions are out of order.");

    a_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_rd |-> $past(w_accept && i_in_data.mode))
        else $error("Buffer read pending without a read request.");

    a_no_read_when_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_mem_re && (ring_idx(r_edit_pos) != ring_idx(w_rp_eff) ||
                                   w_fill == '0))
        else $error("Write lands on an entry that is still unread.");

endmodule

[sim/tb_console_line_editor.sv]
`timescale 1ns / 1ps

module tb_console_line_editor;
    import cle_pkg::*;

    localparam int BUF_DEPTH    = 128;
    localparam int PTR_W        = $clog2(2 * BUF_DEPTH);
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_GAP      = 19;

    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        t_in        req;
        logic       typed;
        logic [1:0] n_res;
        t_out       r0;
        t_out       r1;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    logic [7:0]       line_mem [BUF_DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W-1:0] cm_ptr = '0;
    logic [PTR_W-1:0] ed_ptr = '0;
    t_esc             esc_state = ESC_NONE;

    t_out line_results [$];
    t_row plan [$];
    t_out want;
    int   errors = 0;
    int   answered = 0;
    int   cycles = 0;
    int   out_wait = 0;
    bit   calm = 1'b0;

    always #2 i_clk = ~i_clk;

    console_line_editor #(
        .BUF_DEPTH(BUF_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    function automatic t_out mk_res(logic [2:0] kind, logic [7:0] data, logic [7:0] cnt,
                                    logic eol, logic eof, logic ready, logic last);
        t_out r;
        r.kind = kind;
        r.data = data;
        r.erase_count = cnt;
        r.end_of_line = eol;
        r.end_of_file = eof;
        r.line_ready = ready;
        r.last = last;
        return r;
    endfunction

    function automatic t_in rx_req(logic [7:0] c);
        t_in r;
        r.mode = MODE_RX;
        r.rx_byte = c;
        r.read_started = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_in read_req(logic started);
        t_in r;
        r.mode = MODE_READ;
        r.rx_byte = 8'($urandom_range(0, 255));
        r.read_started = started;
        return r;
    endfunction

    task automatic predict_edit(input t_in req, output t_out r0, output t_out r1,
                                output int n);
        logic [7:0]       c;
        logic [PTR_W-1:0] span;
        r0 = '0;
        r1 = '0;
        n = 0;
        c = req.rx_byte;
        if (req.mode == MODE_READ) begin
            n = 1;
            if (rd_ptr == cm_ptr) begin
                r0 = mk_res(KIND_EMPTY, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
                c = line_mem[rd_ptr[PTR_W-2:0]];
                if (c == CHR_CTRL_D) begin
                    if (!req.read_started) rd_ptr = rd_ptr + 1'b1;
                    r0 = mk_res(KIND_READ, CHR_NUL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    rd_ptr = rd_ptr + 1'b1;
                    r0 = mk_res(KIND_READ, c, 8'd0, c == CHR_NL, 1'b0, 1'b0, 1'b1);
                end
            end
        end else if (esc_state == ESC_DROP1) begin
            esc_state = (c == CHR_BRACKET) ? ESC_DROP2 : ESC_NONE;
        end else if (esc_state == ESC_DROP2) begin
            esc_state = ESC_NONE;
        end else begin
            case (c)
                CHR_CTRL_P: begin
                    r0 = mk_res(KIND_PLIST, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
                    n = 1;
                end
                CHR_CTRL_U: begin
                    span = ed_ptr - cm_ptr;
                    if (span != 0) begin
                        ed_ptr = cm_ptr;
                        r0 = mk_res(KIND_ERASE, CHR_NUL, 8'(span), 1'b0, 1'b0, 1'b0, 1'b1);
                        n = 1;
                    end
                end
                CHR_CTRL_H, CHR_DEL: begin
                    if (ed_ptr != cm_ptr) begin
                        ed_ptr = ed_ptr - 1'b1;
                        r0 = mk_res(KIND_ERASE, CHR_NUL, 8'd1, 1'b0, 1'b0, 1'b0, 1'b1);
                        n = 1;
                    end
                end
                CHR_ESC: begin
                    esc_state = ESC_DROP1;
                end
                default: begin
                    span = ed_ptr - rd_ptr;
                    if (c != CHR_NUL && span < BUF_DEPTH) begin
                        if (c == CHR_CR) c = CHR_NL;
                        line_mem[ed_ptr[PTR_W-2:0]] = c;
                        ed_ptr = ed_ptr + 1'b1;
                        span = ed_ptr - rd_ptr;
                        if (c == CHR_NL || c == CHR_CTRL_D || span == BUF_DEPTH) begin
                            r0 = mk_res(KIND_ECHO, c, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
                            r1 = mk_res(KIND_ECHO, CHR_COMMIT, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
                            cm_ptr = ed_ptr;
                            n = 2;
                        end else begin
                            r0 = mk_res(KIND_ECHO, c, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
                            n = 1;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic submit(input t_in req, input logic typed, input int n_typed,
                          input t_out e0, input t_out e1);
        t_out p0;
        t_out p1;
        int   n;
        int   gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge i_clk); while (in_stall);
        predict_edit(req, p0, p1, n);
        if (typed) begin
            n = n_typed;
            p0 = e0;
            p1 = e1;
        end
        answered++;
        if (n > 0) line_results.push_back(p0);
        if (n > 1) line_results.push_back(p1);
        @(negedge i_clk);
    endtask

    task automatic send(input t_in req);
        submit(req, 1'b0, 0, '0, '0);
    endtask

    task automatic add_row(input t_in req, input logic typed, input int n,
                           input t_out e0, input t_out e1);
        t_row r;
        r.req = req;
        r.typed = typed;
        r.n_res = 2'(n);
        r.r0 = e0;
        r.r1 = e1;
        plan.push_back(r);
    endtask

    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            out_stall <= 1'b1;
            out_wait <= out_wait - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            out_wait <= calm ? 0 : $urandom_range(0, MAX_GAP);
            if (line_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d data %02h", $time,
                         out_data.kind, out_data.data);
                errors++;
            end else begin
                want = line_results.pop_front();
                if (out_data.kind !== want.kind) begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, out_data.kind);
                    errors++;
                end
                if (out_data.data !== want.data) begin
                    $display("%0t: data expected %02h, got %02h", $time, want.data, out_data.data);
                    errors++;
                end
                if (out_data.erase_count !== want.erase_count) begin
                    $display("%0t: erase_count expected %0d, got %0d", $time,
                             want.erase_count, out_data.erase_count);
                    errors++;
                end
                if (out_data.end_of_line !== want.end_of_line) begin
                    $display("%0t: end_of_line expected %0b, got %0b", $time,
                             want.end_of_line, out_data.end_of_line);
                    errors++;
                end
                if (out_data.end_of_file !== want.end_of_file) begin
                    $display("%0t: end_of_file expected %0b, got %0b", $time,
                             want.end_of_file, out_data.end_of_file);
                    errors++;
                end
                if (out_data.line_ready !== want.line_ready) begin
                    $display("%0t: line_ready expected %0b, got %0b", $time,
                             want.line_ready, out_data.line_ready);
                    errors++;
                end
                if (out_data.last !== want.last) begin
                    $display("%0t: last expected %0b, got %0b", $time, want.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int   i;
        int   k;
        int   len;
        int   pick;
        t_out none;
        t_in  noise;
        none = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row(read_req(1'b0), 1'b1, 1,
                mk_res(KIND_EMPTY, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(read_req(1'b1), 1'b1, 1,
                mk_res(KIND_EMPTY, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(rx_req(CHR_CTRL_H), 1'b1, 0, none, none);
        add_row(rx_req(CHR_DEL), 1'b1, 0, none, none);
        add_row(rx_req(CHR_CTRL_U), 1'b1, 0, none, none);
        add_row(rx_req(CHR_NUL), 1'b1, 0, none, none);
        add_row(rx_req(CHR_CTRL_P), 1'b1, 1,
                mk_res(KIND_PLIST, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(rx_req(8'h41), 1'b1, 1,
                mk_res(KIND_ECHO, 8'h41, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(rx_req(8'hff), 1'b1, 1,
                mk_res(KIND_ECHO, 8'hff, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(rx_req(CHR_DEL), 1'b1, 1,
                mk_res(KIND_ERASE, CHR_NUL, 8'd1, 1'b0, 1'b0, 1'b0, 1'b1), none);
        add_row(rx_req(8'h7e), 1'b0, 0, none, none);
        add_row(rx_req(CHR_CTRL_U), 1'b0, 0, none, none);
        add_row(rx_req(CHR_ESC), 1'b1, 0, none, none);
        add_row(rx_req(CHR_BRACKET), 1'b1, 0, none, none);
        add_row(rx_req(8'h58), 1'b1, 0, none, none);
        add_row(rx_req(CHR_ESC), 1'b1, 0, none, none);
        add_row(rx_req(8'h71), 1'b1, 0, none, none);
        add_row(rx_req(8'h71), 1'b0, 0, none, none);
        add_row(rx_req(CHR_CR), 1'b0, 0, none, none);
        add_row(read_req(1'b0), 1'b0, 0, none, none);
        add_row(read_req(1'b1), 1'b0, 0, none, none);
        add_row(rx_req(CHR_CTRL_D), 1'b1, 2,
                mk_res(KIND_ECHO, CHR_CTRL_D, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0),
                mk_res(KIND_ECHO, CHR_COMMIT, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(read_req(1'b1), 1'b1, 1,
                mk_res(KIND_READ, CHR_NUL, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1), none);
        add_row(read_req(1'b1), 1'b0, 0, none, none);
        add_row(read_req(1'b0), 1'b0, 0, none, none);
        add_row(read_req(1'b0), 1'b1, 1,
                mk_res(KIND_EMPTY, CHR_NUL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), none);

        for (i = 0; i < plan.size(); i++) begin
            submit(plan[i].req, plan[i].typed, int'(plan[i].n_res), plan[i].r0, plan[i].r1);
        end

        while (answered < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = $urandom_range(0, 20);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send(rx_req($urandom_range(0, 1) ? CHR_DEL : CHR_CTRL_H));
                    end else begin
                        send(rx_req(8'($urandom_range(8'h20, 8'h7e))));
                    end
                end
                case ($urandom_range(0, 3))
                    0: send(rx_req(CHR_NL));
                    1: send(rx_req(CHR_CR));
                    2: send(rx_req(CHR_CTRL_D));
                    default: send(rx_req(CHR_CTRL_U));
                endcase
            end else if (pick < 70) begin
                len = $urandom_range(1, 50);
                for (k = 0; k < len; k++) send(read_req(1'($urandom_range(0, 1))));
            end else if (pick < 80) begin
                send(rx_req(CHR_ESC));
                if ($urandom_range(0, 1)) send(rx_req(CHR_BRACKET));
                send(rx_req(8'($urandom_range(0, 255))));
            end else if (pick < 85) begin
                len = $urandom_range(100, 140);
                for (k = 0; k < len; k++) send(rx_req(8'($urandom_range(8'h20, 8'hfe))));
                if ($urandom_range(0, 1)) send(rx_req(CHR_CTRL_U));
            end else if (pick < 89) begin
                send(rx_req(CHR_CTRL_P));
            end else begin
                len = $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    noise = t_in'(10'($urandom));
                    send(noise);
                end
            end
        end

        in_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (line_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, line_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
